/* design/atpr_pkg.sv */
package atpr_pkg;

  // Fixed widths that follow from the 16-bit sample format.
  localparam int IN_W       = 16;
  localparam int OUT_W      = 15;
  localparam int SQ_W       = 32;            // p^2 + q^2 of two 16-bit samples
  localparam int RAD_W      = SQ_W + 16;     // radicand is the sum scaled by 2^16
  localparam int ROOT_W     = RAD_W / 2;     // one root bit per digit pair
  localparam int REM_W      = ROOT_W + 3;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int XY_W       = 27;            // CORDIC x/y with headroom for the gain
  localparam int Z_W        = 32;            // angle accumulator, centidegrees in Q16
  localparam int ATAN_LEN   = 24;
  localparam int NUM_SHIFT  = 8;             // numerator scale matches the root scale

  localparam logic signed [Z_W-1:0] ROUND_HALF = 32'sd32768;
  localparam logic signed [Z_W-1:0] ANG_MAX    = 32'sd9000;
  localparam logic signed [Z_W-1:0] ANG_MIN    = -32'sd9000;

  // atan(2^-i) in hundredths of a degree, scaled by 2^16.
  localparam logic signed [Z_W-1:0] ATAN_Q16 [ATAN_LEN] = '{
    32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
    32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
    32'sd1466764,   32'sd733385,    32'sd366693,   32'sd183346,
    32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
    32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
    32'sd358,       32'sd179,       32'sd90,       32'sd45
  };

  typedef struct packed {
    logic [SQ_W-1:0]          sq;
    logic [REM_W-1:0]         rem;
    logic [ROOT_W-1:0]        root;
    logic signed [IN_W-1:0]   num;
    logic                     nz;
  } sqrt_lane_t;

  typedef struct packed {
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [Z_W-1:0]    z;
    logic                     nz;
  } cordic_lane_t;

  // One digit of the restoring square root; k counts digit pairs from the top.
  function automatic sqrt_lane_t sqrt_step(sqrt_lane_t s, int k);
    sqrt_lane_t       o;
    logic [RAD_W-1:0] rad;
    logic [1:0]       pair;
    logic [REM_W-1:0] rem_s;
    logic [REM_W-1:0] trial;
    o     = s;
    rad   = {s.sq, 16'h0000};
    pair  = 2'(rad >> (RAD_W - 2 - 2 * k));
    rem_s = {s.rem[REM_W-3:0], pair};
    trial = REM_W'({s.root, 2'b01});
    if (rem_s >= trial) begin
      o.rem  = rem_s - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = rem_s;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic cordic_lane_t cordic_init(sqrt_lane_t s);
    cordic_lane_t c;
    c.x  = $signed(XY_W'(s.root));
    c.y  = $signed({{(XY_W-IN_W-NUM_SHIFT){s.num[IN_W-1]}}, s.num, {NUM_SHIFT{1'b0}}});
    c.z  = '0;
    c.nz = s.nz;
    return c;
  endfunction

  // One vectoring micro-rotation; the shifts floor toward minus infinity.
  function automatic cordic_lane_t cordic_step(cordic_lane_t c, int i);
    cordic_lane_t           o;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    o  = c;
    xs = c.x >>> i;
    ys = c.y >>> i;
    if (!c.y[XY_W-1]) begin
      o.x = c.x + ys;
      o.y = c.y - xs;
      o.z = c.z + ATAN_Q16[i];
    end else begin
      o.x = c.x - ys;
      o.y = c.y + xs;
      o.z = c.z - ATAN_Q16[i];
    end
    return o;
  endfunction

  // Round the Q16 accumulator to centidegrees, halves up, then limit to +/-90 degrees; a zero numerator gives zero.
  function automatic logic signed [OUT_W-1:0] angle_out(cordic_lane_t c);
    logic signed [Z_W-1:0] t;
    t = (c.z + ROUND_HALF) >>> 16;
    if (!c.nz) begin
      t = '0;
    end else if (t > ANG_MAX) begin
      t = ANG_MAX;
    end else if (t < ANG_MIN) begin
      t = ANG_MIN;
    end
    return OUT_W'(t);
  endfunction

endpackage

/* design/accel_tilt_pitch_roll.sv */
// Pipeline: one squaring stage, one sum stage, 24 square-root digit stages, one CORDIC
// load stage, NS micro-rotations (CORDIC_STAGES, capped at 24) and one rounding stage.
// Throughput: one sample word per cycle while the output is not stalled; the whole
// pipeline advances together.
// Reset clears only the valid bits of every stage; the data registers are not reset.
module accel_tilt_pitch_roll
  import atpr_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [IN_W-1:0]  in_accel_x,
  input  logic signed [IN_W-1:0]  in_accel_y,
  input  logic signed [IN_W-1:0]  in_accel_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_pitch_centideg,
  output logic signed [OUT_W-1:0] out_roll_centideg
);

  // The arctangent table has 24 entries, so deeper settings saturate there.
  localparam int NS = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

  // Lane 0 computes pitch (numerator x over y and z), lane 1 computes roll
  // (numerator y over x and z). Both lanes share the squares of stage one.

  // The pipeline moves as a unit whenever the output register is free or is
  // being emptied this cycle, so a stall freezes every stage in place.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage one: the three squares and the raw numerators.
  logic signed [2*IN_W-1:0] prod_x, prod_y, prod_z;
  logic [SQ_W-2:0]          sqx_r, sqy_r, sqz_r;
  logic signed [IN_W-1:0]   ax_r, ay_r;
  logic                     v1_r;

  assign prod_x = in_accel_x * in_accel_x;
  assign prod_y = in_accel_y * in_accel_y;
  assign prod_z = in_accel_z * in_accel_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      sqx_r <= (SQ_W-1)'(prod_x);
      sqy_r <= (SQ_W-1)'(prod_y);
      sqz_r <= (SQ_W-1)'(prod_z);
      ax_r  <= in_accel_x;
      ay_r  <= in_accel_y;
    end
  end

  // Stage two loads the square-root lanes with the sums of squares.
  sqrt_lane_t [1:0] sr_r [SQRT_STEPS+1];
  logic             vs_r [SQRT_STEPS+1];
  sqrt_lane_t [1:0] sr_init;

  always_comb begin
    sr_init[0].sq   = SQ_W'(sqy_r) + SQ_W'(sqz_r);
    sr_init[0].rem  = '0;
    sr_init[0].root = '0;
    sr_init[0].num  = ax_r;
    sr_init[0].nz   = (ax_r != '0);
    sr_init[1].sq   = SQ_W'(sqx_r) + SQ_W'(sqz_r);
    sr_init[1].rem  = '0;
    sr_init[1].root = '0;
    sr_init[1].num  = ay_r;
    sr_init[1].nz   = (ay_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r[0] <= 1'b0;
    end else if (en) begin
      vs_r[0] <= v1_r;
    end
    if (en) begin
      sr_r[0] <= sr_init;
    end
  end

  // Square-root digit stages: each one resolves one bit of the root per lane.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vs_r[k+1] <= 1'b0;
      end else if (en) begin
        vs_r[k+1] <= vs_r[k];
      end
      if (en) begin
        sr_r[k+1][0] <= sqrt_step(sr_r[k][0], k);
        sr_r[k+1][1] <= sqrt_step(sr_r[k][1], k);
      end
    end
  end

  // CORDIC load: the root becomes x, the numerator scaled by 256 becomes y.
  cordic_lane_t [1:0] cr_r [NS+1];
  logic               vc_r [NS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r[0] <= 1'b0;
    end else if (en) begin
      vc_r[0] <= vs_r[SQRT_STEPS];
    end
    if (en) begin
      cr_r[0][0] <= cordic_init(sr_r[SQRT_STEPS][0]);
      cr_r[0][1] <= cordic_init(sr_r[SQRT_STEPS][1]);
    end
  end

  // Vectoring micro-rotations drive y toward zero and collect the angle in z.
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vc_r[i+1] <= 1'b0;
      end else if (en) begin
        vc_r[i+1] <= vc_r[i];
      end
      if (en) begin
        cr_r[i+1][0] <= cordic_step(cr_r[i][0], i);
        cr_r[i+1][1] <= cordic_step(cr_r[i][1], i);
      end
    end
  end

  // Output register: rounding, clamping and the zero-numerator case.
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] pitch_r, roll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vc_r[NS];
    end
    if (en) begin
      pitch_r <= angle_out(cr_r[NS][0]);
      roll_r  <= angle_out(cr_r[NS][1]);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pitch_centideg = pitch_r;
  assign out_roll_centideg  = roll_r;

  // The finished square root of the pitch lane is the exact floor root.
  a_sqrt_floor: assert property (@(posedge clk) disable iff (!rst_n)
    vs_r[SQRT_STEPS] |->
      ((RAD_W+1)'(sr_r[SQRT_STEPS][0].root) * (RAD_W+1)'(sr_r[SQRT_STEPS][0].root)
         <= (RAD_W+1)'({sr_r[SQRT_STEPS][0].sq, 16'h0000})) &&
      (((RAD_W+1)'(sr_r[SQRT_STEPS][0].root) + 1'b1) *
       ((RAD_W+1)'(sr_r[SQRT_STEPS][0].root) + 1'b1)
         > (RAD_W+1)'({sr_r[SQRT_STEPS][0].sq, 16'h0000})))
    else $error("square root stage gave a wrong root");

  // Both angles stay within plus or minus ninety degrees.
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_centideg <= 15'sd9000) && (out_pitch_centideg >= -15'sd9000))
    else $error("pitch out of range");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_roll_centideg <= 15'sd9000) && (out_roll_centideg >= -15'sd9000))
    else $error("roll out of range");

  // A held result word must survive a stall of the downstream side.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pitch_r) && $stable(roll_r))
    else $error("result word changed while stalled");

endmodule
